FILE: sv/nlsc_pkg.sv
// Shared types and constants for the C numeric literal scanner.
// Holds the scan phase encoding, the per-token state record and kind codes.
// No dependencies.
package nlsc_pkg;

  typedef enum logic [3:0] {
    PH_START   = 4'd0,
    PH_ZERO    = 4'd1,
    PH_DEC     = 4'd2,
    PH_OCT     = 4'd3,
    PH_HEX     = 4'd4,
    PH_FRAC    = 4'd5,
    PH_EXPSIGN = 4'd6,
    PH_EXPDIG  = 4'd7,
    PH_ERR     = 4'd8
  } phase_e;

  typedef struct packed {
    phase_e phase;
    logic   leading_zero;
    logic   octal_valid;
    logic   hex_mode;
    logic   float_seen;
    logic   hex_digit_seen;
  } scan_state_t;

  localparam scan_state_t STATE_RESET = '{
    phase:          PH_START,
    leading_zero:   1'b0,
    octal_valid:    1'b0,
    hex_mode:       1'b0,
    float_seen:     1'b0,
    hex_digit_seen: 1'b0
  };

  localparam logic [1:0] KIND_BAD   = 2'd0;
  localparam logic [1:0] KIND_INT   = 2'd1;
  localparam logic [1:0] KIND_FLOAT = 2'd2;

  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_SEVEN = 8'h37;  // '7'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_LC_A  = 8'h61;  // 'a'
  localparam logic [7:0] CH_LC_F  = 8'h66;  // 'f'
  localparam logic [7:0] CH_UC_A  = 8'h41;  // 'A'
  localparam logic [7:0] CH_UC_F  = 8'h46;  // 'F'
  localparam logic [7:0] CH_LC_E  = 8'h65;  // 'e'
  localparam logic [7:0] CH_UC_E  = 8'h45;  // 'E'
  localparam logic [7:0] CH_LC_P  = 8'h70;  // 'p'
  localparam logic [7:0] CH_UC_P  = 8'h50;  // 'P'
  localparam logic [7:0] CH_LC_X  = 8'h78;  // 'x'
  localparam logic [7:0] CH_UC_X  = 8'h58;  // 'X'

endpackage

FILE: sv/c_numeric_literal_scanner_core.sv
// Top level of the C numeric literal scanner: input register, scan state, result register.
// Instantiates nlsc_step; depends on nlsc_pkg.
//
//   Channel | Signals                           | Direction
//   --------+-----------------------------------+----------
//   in      | in_valid_i, in_ready_o, ch_i, last_i | sink
//   out     | out_valid_o, out_ready_i, kind_o, value_o | source
//
// One character per cycle unless a last character waits on a busy result slot; the
// input register takes each character and the result register takes the verdict
// when the last character leaves the input register, which raises out_valid_o.
// The scan step is a shift-add on the accumulator plus a small phase decode.
// Reset returns the scan state to the start of a token and empties both registers.
// A waiting result stalls only a request that carries the last flag; other
// characters keep flowing while the result sits in its register.
module c_numeric_literal_scanner_core import nlsc_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         ch_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic signed [31:0] value_o
);

  logic                  in_valid_q;
  logic [7:0]            ch_q;
  logic                  last_q;
  scan_state_t           state_q;
  scan_state_t           state_d;
  logic [VALUE_BITS-1:0] acc_q;
  logic [VALUE_BITS-1:0] acc_d;
  logic                  out_valid_q;
  logic [1:0]            kind_q;
  logic [31:0]           value_q;
  logic [1:0]            kind_d;
  logic [31:0]           value_d;
  logic                  advance;

  nlsc_step #(
    .VALUE_BITS(VALUE_BITS)
  ) u_step (
    .state_i(state_q),
    .acc_i  (acc_q),
    .ch_i   (ch_q),
    .state_o(state_d),
    .acc_o  (acc_d),
    .kind_o (kind_d),
    .value_o(value_d)
  );

  // Held request moves on unless it yields a result and the result slot is busy
  assign advance    = in_valid_q && (!last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      state_q     <= STATE_RESET;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (advance) begin
        if (last_q) begin
          state_q <= STATE_RESET;
          acc_q   <= '0;
        end else begin
          state_q <= state_d;
          acc_q   <= acc_d;
        end
      end
      if (advance && last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ch_q   <= ch_i;
      last_q <= last_i;
    end
    if (advance && last_q) begin
      kind_q  <= kind_d;
      value_q <= value_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign value_o     = signed'(value_q);

endmodule

FILE: sv/nlsc_step.sv
// Single-character step of the scanner: next state, accumulator and result kind.
// Purely combinational; sits between the input register and the result register.
// Depends on nlsc_pkg.
module nlsc_step import nlsc_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  scan_state_t           state_i,
  input  logic [VALUE_BITS-1:0] acc_i,
  input  logic [7:0]            ch_i,
  output scan_state_t           state_o,
  output logic [VALUE_BITS-1:0] acc_o,
  output logic [1:0]            kind_o,
  output logic [31:0]           value_o
);

  logic                  is_dec;
  logic                  is_lc_hex;
  logic                  is_uc_hex;
  logic                  is_hex;
  logic [3:0]            hex_val;
  logic [VALUE_BITS-1:0] dig;
  logic [VALUE_BITS-1:0] hdig;
  logic [63:0]           acc_ext;

  // Character that may open a fraction or an exponent after a digit run
  function automatic phase_e after_phase(input logic [7:0] c, input logic allow_dot,
                                         input logic hex);
    phase_e ph;
    if (allow_dot && c == CH_DOT) begin
      ph = PH_FRAC;
    end else if (c == CH_LC_E || c == CH_UC_E) begin
      ph = hex ? PH_ERR : PH_EXPSIGN;
    end else if (c == CH_LC_P || c == CH_UC_P) begin
      ph = hex ? PH_EXPSIGN : PH_ERR;
    end else begin
      ph = PH_ERR;
    end
    return ph;
  endfunction

  function automatic logic after_float(input logic [7:0] c, input logic allow_dot);
    return (allow_dot && c == CH_DOT) || c == CH_LC_E || c == CH_UC_E ||
           c == CH_LC_P || c == CH_UC_P;
  endfunction

  assign is_dec    = (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);
  assign is_lc_hex = (ch_i >= CH_LC_A) && (ch_i <= CH_LC_F);
  assign is_uc_hex = (ch_i >= CH_UC_A) && (ch_i <= CH_UC_F);
  assign is_hex    = is_dec || is_lc_hex || is_uc_hex;
  // letters: low nibble of 'a'/'A' is 1, so add 9
  assign hex_val   = is_dec ? ch_i[3:0] : ch_i[3:0] + 4'd9;
  assign dig       = VALUE_BITS'(ch_i[3:0]);
  assign hdig      = VALUE_BITS'(hex_val);

  always_comb begin
    state_o = state_i;
    acc_o   = acc_i;
    unique case (state_i.phase)
      PH_START: begin
        if (ch_i == CH_ZERO) begin
          state_o.phase = PH_ZERO;
          acc_o         = '0;
        end else if (is_dec) begin
          state_o.phase = PH_DEC;
          acc_o         = dig;
        end else if (ch_i == CH_DOT) begin
          state_o.phase      = PH_FRAC;
          state_o.float_seen = 1'b1;
        end else begin
          state_o.phase = PH_ERR;
        end
      end
      PH_ZERO: begin
        if (is_dec) begin
          state_o.phase        = PH_OCT;
          state_o.leading_zero = 1'b1;
          state_o.octal_valid  = (ch_i <= CH_SEVEN);
          acc_o                = dig;
        end else if (ch_i == CH_LC_X || ch_i == CH_UC_X) begin
          state_o.phase    = PH_HEX;
          state_o.hex_mode = 1'b1;
        end else begin
          state_o.phase = after_phase(ch_i, 1'b1, state_i.hex_mode);
          if (after_float(ch_i, 1'b1)) state_o.float_seen = 1'b1;
        end
      end
      PH_DEC: begin
        if (is_dec) begin
          acc_o = (acc_i << 3) + (acc_i << 1) + dig;  // times ten
        end else begin
          state_o.phase = after_phase(ch_i, 1'b1, state_i.hex_mode);
          if (after_float(ch_i, 1'b1)) state_o.float_seen = 1'b1;
        end
      end
      PH_OCT: begin
        if (is_dec) begin
          if (ch_i > CH_SEVEN) state_o.octal_valid = 1'b0;
          acc_o = (acc_i << 3) + dig;
        end else begin
          state_o.phase = after_phase(ch_i, 1'b1, state_i.hex_mode);
          if (after_float(ch_i, 1'b1)) state_o.float_seen = 1'b1;
        end
      end
      PH_HEX: begin
        if (is_hex) begin
          state_o.hex_digit_seen = 1'b1;
          acc_o                  = (acc_i << 4) + hdig;
        end else begin
          state_o.phase = after_phase(ch_i, 1'b1, state_i.hex_mode);
          if (after_float(ch_i, 1'b1)) state_o.float_seen = 1'b1;
        end
      end
      PH_FRAC: begin
        if (state_i.hex_mode) begin
          if (is_hex) begin
            state_o.hex_digit_seen = 1'b1;
          end else begin
            state_o.phase = after_phase(ch_i, 1'b0, state_i.hex_mode);
            if (after_float(ch_i, 1'b0)) state_o.float_seen = 1'b1;
          end
        end else if (!is_dec) begin
          state_o.phase = after_phase(ch_i, 1'b0, state_i.hex_mode);
          if (after_float(ch_i, 1'b0)) state_o.float_seen = 1'b1;
        end
      end
      PH_EXPSIGN: begin
        state_o.phase = (ch_i == CH_PLUS || ch_i == CH_MINUS || is_dec) ? PH_EXPDIG : PH_ERR;
      end
      PH_EXPDIG: begin
        if (!is_dec) state_o.phase = PH_ERR;
      end
      default: begin
        state_o.phase = PH_ERR;
      end
    endcase
  end

  assign acc_ext = 64'(acc_o);

  // Verdict on the post-step state; only used when the character is the last
  always_comb begin
    kind_o  = KIND_BAD;
    value_o = '0;
    if (state_o.phase == PH_ERR || (state_o.hex_mode && !state_o.hex_digit_seen)) begin
      kind_o = KIND_BAD;
    end else if (state_o.float_seen) begin
      kind_o = KIND_FLOAT;
    end else if (state_o.leading_zero && !state_o.octal_valid) begin
      kind_o = KIND_BAD;
    end else begin
      kind_o  = KIND_INT;
      value_o = acc_ext[31:0];
    end
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for c_numeric_literal_scanner_core. It sends C numeric literal
// tokens one character per request, predicts kind and value for each token and checks them.
// Depends on nlsc_pkg and the scanner RTL.
module testbench;
  import nlsc_pkg::*;

  typedef struct {
    logic [1:0]         kind;
    logic signed [31:0] value;
  } lit_result_t;

  // Token state tracker plus the queue of literal results still owed by the block.
  class literal_scoreboard;
    phase_e      phase;
    bit          leading_zero;
    bit          octal_ok;
    bit          hex_mode;
    bit          float_seen;
    bit          hex_seen;
    logic [31:0] acc;
    lit_result_t owed_q[$];
    int          errors;

    function new();
      errors = 0;
      clear_token();
    endfunction

    function void clear_token();
      phase        = PH_START;
      leading_zero = 1'b0;
      octal_ok     = 1'b0;
      hex_mode     = 1'b0;
      float_seen   = 1'b0;
      hex_seen     = 1'b0;
      acc          = '0;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function int hex_digit(logic [7:0] c);
      if (is_digit(c)) return int'(c - CH_ZERO);
      if (c >= CH_LC_A && c <= CH_LC_F) return int'(c - CH_LC_A) + 10;
      if (c >= CH_UC_A && c <= CH_UC_F) return int'(c - CH_UC_A) + 10;
      return -1;
    endfunction

    // Character after a digit run: fraction dot, exponent letter or junk.
    function void leave_digits(logic [7:0] c, bit dot_ok);
      if (dot_ok && c == CH_DOT) begin
        phase      = PH_FRAC;
        float_seen = 1'b1;
      end else if (c == CH_LC_E || c == CH_UC_E) begin
        if (hex_mode) phase = PH_ERR;
        else phase = PH_EXPSIGN;
        float_seen = 1'b1;
      end else if (c == CH_LC_P || c == CH_UC_P) begin
        if (hex_mode) phase = PH_EXPSIGN;
        else phase = PH_ERR;
        float_seen = 1'b1;
      end else begin
        phase = PH_ERR;
      end
    endfunction

    function void note_char(logic [7:0] c, logic lst);
      int          hv;
      lit_result_t r;
      hv = hex_digit(c);
      case (phase)
        PH_START: begin
          if (c == CH_ZERO) begin
            phase = PH_ZERO;
            acc   = '0;
          end else if (is_digit(c)) begin
            phase = PH_DEC;
            acc   = {24'd0, c - CH_ZERO};
          end else if (c == CH_DOT) begin
            phase      = PH_FRAC;
            float_seen = 1'b1;
          end else begin
            phase = PH_ERR;
          end
        end
        PH_ZERO: begin
          if (is_digit(c)) begin
            phase        = PH_OCT;
            leading_zero = 1'b1;
            octal_ok     = (c <= CH_SEVEN);
            acc          = {24'd0, c - CH_ZERO};
          end else if (c == CH_LC_X || c == CH_UC_X) begin
            phase    = PH_HEX;
            hex_mode = 1'b1;
          end else begin
            leave_digits(c, 1'b1);
          end
        end
        PH_DEC: begin
          if (is_digit(c)) acc = acc * 32'd10 + {24'd0, c - CH_ZERO};
          else leave_digits(c, 1'b1);
        end
        PH_OCT: begin
          if (is_digit(c)) begin
            if (c > CH_SEVEN) octal_ok = 1'b0;
            acc = {acc[28:0], 3'b000} + {24'd0, c - CH_ZERO};
          end else begin
            leave_digits(c, 1'b1);
          end
        end
        PH_HEX: begin
          if (hv >= 0) begin
            hex_seen = 1'b1;
            acc      = {acc[27:0], 4'b0000} + 32'(hv);
          end else begin
            leave_digits(c, 1'b1);
          end
        end
        PH_FRAC: begin
          if (hex_mode) begin
            if (hv >= 0) hex_seen = 1'b1;
            else leave_digits(c, 1'b0);
          end else if (!is_digit(c)) begin
            leave_digits(c, 1'b0);
          end
        end
        PH_EXPSIGN: begin
          if (c == CH_PLUS || c == CH_MINUS || is_digit(c)) phase = PH_EXPDIG;
          else phase = PH_ERR;
        end
        PH_EXPDIG: begin
          if (!is_digit(c)) phase = PH_ERR;
        end
        default: phase = PH_ERR;
      endcase

      if (lst) begin
        r.value = '0;
        if (phase == PH_ERR || (hex_mode && !hex_seen)) begin
          r.kind = KIND_BAD;
        end else if (float_seen) begin
          r.kind = KIND_FLOAT;
        end else if (leading_zero && !octal_ok) begin
          r.kind = KIND_BAD;
        end else begin
          r.kind  = KIND_INT;
          r.value = acc;
        end
        owed_q.push_back(r);
        clear_token();
      end
    endfunction

    function void check_result(logic [1:0] kind, logic signed [31:0] value);
      lit_result_t e;
      if (owed_q.size() == 0) begin
        $error("unexpected result: kind %0d value %0d", kind, value);
        errors++;
        return;
      end
      e = owed_q.pop_front();
      if (kind !== e.kind) begin
        $error("kind: expected %0d, actual %0d", e.kind, kind);
        errors++;
      end
      if (value !== e.value) begin
        $error("value: expected %0d, actual %0d", e.value, value);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         ch_i;
  logic               last_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [1:0]         kind_o;
  logic signed [31:0] value_o;

  literal_scoreboard sb;
  logic [7:0]        token_q[$];
  int                chars_sent;
  int                stall_left;
  bit                calm;       // no random idling on either side while set
  bit                park_req;

  c_numeric_literal_scanner_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .ch_i       (ch_i),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .kind_o     (kind_o),
    .value_o    (value_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic logic [7:0] dec_ch();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] hex_ch();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return CH_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? CH_LC_A : CH_UC_A) + 8'(v - 10);
  endfunction

  // Mostly short runs; now and then long enough to wrap the accumulator.
  function automatic int draw_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(5, 14);
    return $urandom_range(0, 4);
  endfunction

  function automatic void add_digits(int n, int radix);
    repeat (n) begin
      if (radix == 16) token_q.push_back(hex_ch());
      else if (radix == 8) token_q.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
      else token_q.push_back(dec_ch());
    end
  endfunction

  function automatic void add_exp(bit hex);
    if (hex) token_q.push_back($urandom_range(0, 1) ? CH_LC_P : CH_UC_P);
    else token_q.push_back($urandom_range(0, 1) ? CH_LC_E : CH_UC_E);
    case ($urandom_range(0, 2))
      0: token_q.push_back(CH_PLUS);
      1: token_q.push_back(CH_MINUS);
      default: ;
    endcase
    add_digits($urandom_range(0, 3), 10);
  endfunction

  function automatic void build_random();
    int form;
    int pos;
    token_q.delete();
    form = $urandom_range(0, 99);
    if (form < 15) begin
      token_q.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
      add_digits(draw_len(), 10);
    end else if (form < 25) begin
      // octal, sometimes with an 8 or 9, sometimes rescued by a fraction
      token_q.push_back(CH_ZERO);
      add_digits(draw_len() + 1, ($urandom_range(0, 3) == 0) ? 10 : 8);
      if ($urandom_range(0, 4) == 0) token_q.push_back(CH_DOT);
    end else if (form < 40) begin
      token_q.push_back(CH_ZERO);
      token_q.push_back($urandom_range(0, 1) ? CH_LC_X : CH_UC_X);
      add_digits(($urandom_range(0, 9) == 0) ? 0 : draw_len() + 1, 16);
    end else if (form < 55) begin
      add_digits(draw_len(), 10);
      if ($urandom_range(0, 3) != 0) begin
        token_q.push_back(CH_DOT);
        add_digits(draw_len(), 10);
      end
      if ($urandom_range(0, 1)) add_exp(1'b0);
      if (token_q.size() == 0) token_q.push_back(CH_DOT);
    end else if (form < 65) begin
      token_q.push_back(CH_ZERO);
      token_q.push_back($urandom_range(0, 1) ? CH_LC_X : CH_UC_X);
      add_digits(draw_len(), 16);
      if ($urandom_range(0, 1)) begin
        token_q.push_back(CH_DOT);
        add_digits(draw_len(), 16);
      end
      add_exp(1'b1);
    end else if (form < 72) begin
      token_q.push_back(dec_ch());
    end else if (form < 88) begin
      // well-formed number with one random byte inserted, which usually spoils it
      add_digits(draw_len() + 1, 10);
      if ($urandom_range(0, 1)) begin
        token_q.push_back(CH_DOT);
        add_digits(draw_len(), 10);
      end
      pos = $urandom_range(0, token_q.size());
      token_q.insert(pos, 8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 5)) token_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic send_char(logic [7:0] c, logic lst);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 17);
    repeat (gap) @(negedge clk_i) in_valid_i <= 1'b0;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    ch_i       <= c;
    last_i     <= lst;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_char(c, lst);
    chars_sent++;
  endtask

  task automatic send_token();
    foreach (token_q[i]) send_char(token_q[i], i == token_q.size() - 1);
  endtask

  task automatic send_str(string s);
    token_q.delete();
    for (int i = 0; i < s.len(); i++) token_q.push_back(s[i]);
    send_token();
  endtask

  // Result side: a fresh stall is drawn after every accepted result.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(kind_o, value_o);
      stall_left = calm ? 0 : $urandom_range(0, 17);
    end
  end

  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (park_req) begin
        park_req   = 1'b0;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    bit parked;
    sb         = new();
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    ch_i       = '0;
    last_i     = 1'b0;
    chars_sent = 0;
    stall_left = 0;
    calm       = 1'b0;
    park_req   = 1'b0;
    parked     = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    send_str("0");
    send_str("4294967295");
    send_str("4294967296");
    send_str("0777");
    send_str("089");
    send_str("089.e1");
    send_str("0x");
    send_str("0x.p1");
    send_str("0XfFaB1e");
    send_str("0x1.8p-3");
    send_str("0x1p");
    send_str("1e5");
    send_str("1E+");
    send_str(".");
    send_str(".5e-");
    send_str("1p3");
    send_str("1.2.3");
    send_str("12u");
    send_str("a1");
    send_str("08");
    token_q = '{8'h31, 8'h00};
    send_token();
    token_q = '{8'hFF};
    send_token();
    token_q = '{8'h37, 8'h80, 8'h35};
    send_token();

    while (chars_sent < 1050) begin
      if ($urandom_range(0, 29) == 0) calm = ~calm;
      // hold results back for a long stretch while requests keep coming
      if (!parked && chars_sent > 500) begin
        parked   = 1'b1;
        park_req = 1'b1;
      end
      build_random();
      send_token();
    end
    calm = 1'b0;

    @(negedge clk_i) in_valid_i <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: c_numeric_literal_scanner_core.f
sv/nlsc_pkg.sv
sv/nlsc_step.sv
sv/c_numeric_literal_scanner_core.sv
sim/testbench.sv
